// ===== rtl/core/xtea_pkg.sv =====
package xtea_pkg;

  localparam int unsigned WordW         = 32;
  localparam int unsigned NumKeyWords   = 4;
  localparam int unsigned KeyIdxW       = 2;
  localparam int unsigned KeyShift      = 11;
  localparam int unsigned RoundsDefault = 32;
  localparam logic [WordW-1:0] Delta    = 32'h9E37_79B9;

  // Action codes carried with each item.
  localparam logic ActEncrypt = 1'b0;
  localparam logic ActDecrypt = 1'b1;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumKeyWords-1:0][WordW-1:0] key_t;

  typedef struct packed {
    logic  act;
    word_t w0;
    word_t w1;
  } blk_t;

  // One XTEA half-round mixing term.
  function automatic word_t mix(input word_t x, input word_t sum, input word_t key);
    word_t t;
    t = ((x << 4) ^ (x >> 5)) + x;
    return t ^ (sum + key);
  endfunction

endpackage

// ===== rtl/core/xtea_cell.sv =====
module xtea_cell #(
  parameter logic        Odd    = 1'b0,
  parameter logic [31:0] SumEnc = 32'h0,
  parameter logic [31:0] SumDec = 32'h0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  xtea_pkg::blk_t blk_i,
  input  xtea_pkg::key_t key_i,
  output logic          valid_o,
  output xtea_pkg::blk_t blk_o
);
  import xtea_pkg::*;

  logic   valid_q;
  blk_t   blk_q, blk_d;
  logic   swap;
  word_t  src, dst, sum, m, nd;
  logic [KeyIdxW-1:0] kidx;

  // Encryption updates y on even cells and z on odd cells; decryption is the reverse,
  // and the key-select bits follow the updated word.
  always_comb begin
    swap = blk_i.act ^ Odd;
    src  = swap ? blk_i.w0 : blk_i.w1;
    dst  = swap ? blk_i.w1 : blk_i.w0;
    sum  = (blk_i.act == ActDecrypt) ? SumDec : SumEnc;
    kidx = swap ? sum[KeyShift +: KeyIdxW] : sum[KeyIdxW-1:0];
    m    = mix(src, sum, key_i[kidx]);
    nd   = (blk_i.act == ActDecrypt) ? (dst - m) : (dst + m);
    blk_d.act = blk_i.act;
    blk_d.w0  = swap ? blk_i.w0 : nd;
    blk_d.w1  = swap ? nd : blk_i.w1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

// ===== rtl/core/xtea_block_cipher_core.sv =====
// XTEA block cipher, 64-bit block, 128-bit key.
// Input channel: in_valid_i/in_ready_o with action_i (0 encrypts, 1 decrypts)
// and the two block words. Output channel: out_valid_o/out_ready_i with the
// two result words. Configuration: cfg_valid_i/cfg_ready_o writes cfg_data_i
// into key word cfg_index_i; the user must see that the key is changed only
// while no item is in flight, the block itself does not enforce it. The
// datapath is a chain of 2*ROUNDS cells of one module, one half round each;
// one item is accepted every cycle while the receiver keeps up. The last
// cell is the output register. While it holds an item that the receiver
// does not take, the whole chain holds and in_ready_o is low; items keep
// their order and none is dropped.
// Reset clears all cell valid bits and sets the key words to zero.
module xtea_block_cipher_core #(
  parameter int unsigned ROUNDS = xtea_pkg::RoundsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [31:0]                   block_word0_i,
  input  logic [31:0]                   block_word1_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   result_word0_o,
  output logic [31:0]                   result_word1_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [xtea_pkg::KeyIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import xtea_pkg::*;

  localparam int unsigned Stages = 2 * ROUNDS;

  key_t key_q;
  logic advance;
  logic [Stages:0] valid_c;
  blk_t            blk_c [Stages+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i) begin
      key_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  assign valid_c[0]    = in_valid_i;
  assign blk_c[0].act  = action_i;
  assign blk_c[0].w0   = block_word0_i;
  assign blk_c[0].w1   = block_word1_i;

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    localparam int unsigned Rnd   = g / 2;
    localparam logic        IsOdd = (g % 2) == 1;
    localparam int unsigned KEnc  = IsOdd ? Rnd + 1 : Rnd;
    localparam int unsigned KDec  = IsOdd ? ROUNDS - Rnd - 1 : ROUNDS - Rnd;
    localparam logic [63:0] PEnc  = 64'(KEnc) * 64'(Delta);
    localparam logic [63:0] PDec  = 64'(KDec) * 64'(Delta);

    xtea_cell #(
      .Odd    (IsOdd),
      .SumEnc (PEnc[31:0]),
      .SumDec (PDec[31:0])
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (valid_c[g]),
      .blk_i   (blk_c[g]),
      .key_i   (key_q),
      .valid_o (valid_c[g+1]),
      .blk_o   (blk_c[g+1])
    );
  end

  assign out_valid_o    = valid_c[Stages];
  assign result_word0_o = blk_c[Stages].w0;
  assign result_word1_o = blk_c[Stages].w1;

endmodule

// ===== rtl/core/xtea_checker.sv =====
module xtea_checker #(
  parameter int unsigned ROUNDS = xtea_pkg::RoundsDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [31:0]                   result_word0_o,
  input logic [31:0]                   result_word1_o
);

  localparam int unsigned Depth = 2 * ROUNDS;
  localparam int unsigned CntW  = $clog2(Depth + 2);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_word0_o)
      && $stable(result_word1_o))
    else $error("result changed while stalled");

  // The input side only stalls behind a waiting result.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // No result without an item in flight.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result without an accepted item");

  // The chain never holds more items than it has cells.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("more items in flight than cells");

endmodule

bind xtea_block_cipher_core xtea_checker #(.ROUNDS(ROUNDS)) u_xtea_checker (.*);
